@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/fgcc_pkg.sv @@
// ---------------------------------------------------------------------------
// Frost-guarded cooling controller package
// Register map, control modes, reset values and output codes.
// ---------------------------------------------------------------------------
package fgcc_pkg;

	localparam int TEMP_W = 12;
	localparam int CNT_W = 3;
	localparam int RETRY_W = 10;
	localparam int BAND_W = 8;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_MANUAL  = 2'd1,
		MODE_THERMO  = 2'd2,
		MODE_REMOTE  = 2'd3
	} ctrl_mode_t;

	typedef enum logic [2:0] {
		REG_FROST_LIMIT   = 3'd0,
		REG_WARM_LIMIT    = 3'd1,
		REG_FROST_CNT_LIM = 3'd2,
		REG_RETRY_PERIODS = 3'd3,
		REG_CONTROL_MODE  = 3'd4,
		REG_SETPOINT      = 3'd5,
		REG_BAND_HIGH     = 3'd6,
		REG_BAND_LOW      = 3'd7
	} reg_idx_t;

	localparam logic [1:0] PRESSES_NONE = 2'd0;
	localparam logic [1:0] PRESSES_SWITCH = 2'd2;

	localparam logic signed [TEMP_W-1:0] FROST_LIMIT_RST = 12'sd320;
	localparam logic signed [TEMP_W-1:0] WARM_LIMIT_RST = 12'sd340;
	localparam logic [CNT_W-1:0] FROST_CNT_LIM_RST = 3'd5;
	localparam logic [RETRY_W-1:0] RETRY_PERIODS_RST = 10'd90;
	localparam logic signed [TEMP_W-1:0] SETPOINT_RST = 12'sd650;
	localparam logic [BAND_W-1:0] BAND_HIGH_RST = 8'd20;
	localparam logic [BAND_W-1:0] BAND_LOW_RST = 8'd20;

endpackage

@@ hw/rtl/frost_guarded_cooling_controller.sv @@
// ---------------------------------------------------------------------------
// Frost-guarded cooling controller
// Frost fault counter, fan-only retry hold-off and relay control, one
// evaluation period per item transfer.
// ---------------------------------------------------------------------------
//  Channel   Handshake                       Payload
//  item      item_valid / item_ready         cond_temp, room_temp, pins, requests
//  result    result_valid / result_ready     pump_on, fan_on, frost_fault,
//                                            mode_presses, fault_led, cool_mode
//  config    psel / penable / pwrite         paddr, pwdata, prdata
//
// An item is held in the input register and then moves to the result register,
// where all controller state is updated in the same cycle. One item can be
// accepted every cycle while the result is not stalled. A stalled result holds
// the result register; the input register still takes one more item. Reset
// loads the register defaults, sets the cool-mode flag and clears other state.
// ---------------------------------------------------------------------------
module frost_guarded_cooling_controller
	import fgcc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic signed [TEMP_W-1:0]  cond_temp,
	input  logic signed [TEMP_W-1:0]  room_temp,
	input  logic                      demand_pin_active,
	input  logic                      manmode_pin_active,
	input  logic                      manual_pump,
	input  logic                      manual_fan,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic                      pump_on,
	output logic                      fan_on,
	output logic                      frost_fault,
	output logic [1:0]                mode_presses,
	output logic                      fault_led,
	output logic                      cool_mode
);

	logic signed [TEMP_W-1:0] frost_limit_q;
	logic signed [TEMP_W-1:0] warm_limit_q;
	logic [CNT_W-1:0]         frost_cnt_lim_q;
	logic [RETRY_W-1:0]       retry_periods_q;
	ctrl_mode_t               control_mode_q;
	logic signed [TEMP_W-1:0] setpoint_q;
	logic [BAND_W-1:0]        band_high_q;
	logic [BAND_W-1:0]        band_low_q;

	logic [CNT_W-1:0]   frost_count_q;
	logic               frost_flag_q;
	logic               cool_flag_q;
	logic               retry_running_q;
	logic [RETRY_W-1:0] retry_elapsed_q;
	logic               pump_relay_q;
	logic               fan_relay_q;
	logic               led_level_q;

	logic                     valid_s1;
	logic signed [TEMP_W-1:0] cond_s1;
	logic signed [TEMP_W-1:0] room_s1;
	logic                     demand_s1;
	logic                     manmode_s1;
	logic                     man_pump_s1;
	logic                     man_fan_s1;

	logic       valid_s2;
	logic [1:0] presses_s2;

	logic               advance;
	logic               cfg_write;
	reg_idx_t           cfg_idx;
	logic               cold;
	logic [CNT_W-1:0]   frost_count_d;
	logic [CNT_W-1:0]   cnt_dec;
	logic               frost_flag_d;
	logic               expired;
	logic               cool_flag_d;
	logic               retry_running_d;
	logic [RETRY_W-1:0] retry_elapsed_d;
	logic               led_level_d;
	logic [1:0]         presses_d;
	logic               pump_relay_d;
	logic               fan_relay_d;
	logic               pump_tmp;
	logic               demand;
	logic signed [TEMP_W+1:0] room_x;
	logic signed [TEMP_W+1:0] on_thresh;
	logic signed [TEMP_W+1:0] off_thresh;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frost_limit_q <= FROST_LIMIT_RST;
			warm_limit_q <= WARM_LIMIT_RST;
			frost_cnt_lim_q <= FROST_CNT_LIM_RST;
			retry_periods_q <= RETRY_PERIODS_RST;
			control_mode_q <= MODE_THERMO;
			setpoint_q <= SETPOINT_RST;
			band_high_q <= BAND_HIGH_RST;
			band_low_q <= BAND_LOW_RST;
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_FROST_LIMIT: frost_limit_q <= pwdata[TEMP_W-1:0];
				REG_WARM_LIMIT: warm_limit_q <= pwdata[TEMP_W-1:0];
				REG_FROST_CNT_LIM: frost_cnt_lim_q <= pwdata[CNT_W-1:0];
				REG_RETRY_PERIODS: retry_periods_q <= pwdata[RETRY_W-1:0];
				REG_CONTROL_MODE: control_mode_q <= ctrl_mode_t'(pwdata[1:0]);
				REG_SETPOINT: setpoint_q <= pwdata[TEMP_W-1:0];
				REG_BAND_HIGH: band_high_q <= pwdata[BAND_W-1:0];
				REG_BAND_LOW: band_low_q <= pwdata[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_FROST_LIMIT: prdata = {{(DATA_W-TEMP_W){1'b0}}, frost_limit_q};
			REG_WARM_LIMIT: prdata = {{(DATA_W-TEMP_W){1'b0}}, warm_limit_q};
			REG_FROST_CNT_LIM: prdata = {{(DATA_W-CNT_W){1'b0}}, frost_cnt_lim_q};
			REG_RETRY_PERIODS: prdata = {{(DATA_W-RETRY_W){1'b0}}, retry_periods_q};
			REG_CONTROL_MODE: prdata = {{(DATA_W-2){1'b0}}, control_mode_q};
			REG_SETPOINT: prdata = {{(DATA_W-TEMP_W){1'b0}}, setpoint_q};
			REG_BAND_HIGH: prdata = {{(DATA_W-BAND_W){1'b0}}, band_high_q};
			REG_BAND_LOW: prdata = {{(DATA_W-BAND_W){1'b0}}, band_low_q};
			default: prdata = '0;
		endcase
	end

	// The result register moves on when it is empty or being drained.
	assign advance = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			cond_s1 <= cond_temp;
			room_s1 <= room_temp;
			demand_s1 <= demand_pin_active;
			manmode_s1 <= manmode_pin_active;
			man_pump_s1 <= manual_pump;
			man_fan_s1 <= manual_fan;
		end
	end

	always_comb begin
		cold = cond_s1 < frost_limit_q;
		cnt_dec = (frost_count_q != '0) ? frost_count_q - 1'b1 : frost_count_q;
		frost_count_d = frost_count_q;
		frost_flag_d = frost_flag_q;
		if (cold) begin
			if (frost_count_q >= frost_cnt_lim_q) begin
				frost_count_d = '0;
				frost_flag_d = 1'b1;
			end else begin
				frost_count_d = frost_count_q + 1'b1;
			end
		end else if (frost_flag_q) begin
			frost_count_d = cnt_dec;
			if (cnt_dec == '0) begin
				frost_flag_d = !(cond_s1 > warm_limit_q);
			end
		end
	end

	always_comb begin
		expired = retry_running_q && (retry_elapsed_q >= retry_periods_q);
		cool_flag_d = cool_flag_q;
		retry_running_d = retry_running_q;
		retry_elapsed_d = retry_elapsed_q;
		led_level_d = led_level_q;
		presses_d = PRESSES_NONE;
		if (frost_flag_d && !retry_running_q) begin
			cool_flag_d = 1'b0;
			led_level_d = 1'b1;
			retry_running_d = 1'b1;
			retry_elapsed_d = '0;
			presses_d = PRESSES_SWITCH;
		end else if (!retry_running_q || expired) begin
			retry_running_d = 1'b0;
			retry_elapsed_d = '0;
			if (!cool_flag_q) begin
				cool_flag_d = 1'b1;
				presses_d = PRESSES_SWITCH;
			end else begin
				led_level_d = 1'b0;
			end
		end else begin
			retry_elapsed_d = retry_elapsed_q + 1'b1;
			if (!cold) begin
				led_level_d = !led_level_q;
			end
		end
	end

	assign demand = demand_s1 && manmode_s1;
	assign room_x = (TEMP_W+2)'(room_s1);
	assign on_thresh = (TEMP_W+2)'(setpoint_q) + $signed({6'b0, band_high_q});
	assign off_thresh = (TEMP_W+2)'(setpoint_q) - $signed({6'b0, band_low_q});

	always_comb begin
		pump_tmp = pump_relay_q;
		pump_relay_d = pump_relay_q;
		fan_relay_d = fan_relay_q;
		case (control_mode_q)
			MODE_MANUAL: begin
				pump_relay_d = man_pump_s1;
				fan_relay_d = man_fan_s1;
			end
			MODE_THERMO: begin
				pump_relay_d = demand && !frost_flag_d;
				fan_relay_d = demand || frost_flag_d;
			end
			MODE_REMOTE: begin
				fan_relay_d = 1'b1;
				if (!frost_flag_d && !pump_relay_q && (room_x >= on_thresh)) begin
					pump_tmp = 1'b1;
				end
				if (frost_flag_d || (pump_tmp && (room_x <= off_thresh))) begin
					pump_relay_d = 1'b0;
				end else begin
					pump_relay_d = pump_tmp;
				end
			end
			default: begin
				pump_relay_d = 1'b0;
				fan_relay_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frost_count_q <= '0;
			frost_flag_q <= 1'b0;
			cool_flag_q <= 1'b1;
			retry_running_q <= 1'b0;
			retry_elapsed_q <= '0;
			pump_relay_q <= 1'b0;
			fan_relay_q <= 1'b0;
			led_level_q <= 1'b0;
		end else if (advance) begin
			frost_count_q <= frost_count_d;
			frost_flag_q <= frost_flag_d;
			cool_flag_q <= cool_flag_d;
			retry_running_q <= retry_running_d;
			retry_elapsed_q <= retry_elapsed_d;
			pump_relay_q <= pump_relay_d;
			fan_relay_q <= fan_relay_d;
			led_level_q <= led_level_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			presses_s2 <= presses_d;
		end
	end

	assign result_valid = valid_s2;
	assign pump_on = pump_relay_q;
	assign fan_on = fan_relay_q;
	assign frost_fault = frost_flag_q;
	assign mode_presses = presses_s2;
	assign fault_led = led_level_q;
	assign cool_mode = cool_flag_q;

endmodule

@@ hw/rtl/fgcc_checker.sv @@
// ---------------------------------------------------------------------------
// Frost-guarded cooling controller checker
// Port-level assertions on the result channel and the item handshake.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fgcc_checker
	import fgcc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic       pump_on,
	input logic       fan_on,
	input logic       frost_fault,
	input logic [1:0] mode_presses,
	input logic       fault_led,
	input logic       cool_mode
);

	logic       presses_legal;
	logic       trip_shown;
	logic       stalled;
	logic [6:0] fields;

	assign presses_legal = (mode_presses == PRESSES_NONE) || (mode_presses == PRESSES_SWITCH);
	assign trip_shown = result_valid && (mode_presses == PRESSES_SWITCH) && !cool_mode;
	assign stalled = result_valid && !result_ready;
	assign fields = {pump_on, fan_on, frost_fault, mode_presses, fault_led, cool_mode};

	// Only no press or a full mode switch is ever requested.
	`ASSERT_IMPLIES(a_presses_code, clk, arst_n, result_valid, presses_legal)

	// A switch into fan-only mode always lights the fault LED.
	`ASSERT_IMPLIES(a_trip_led, clk, arst_n, trip_shown, fault_led)

	// With no result waiting, the block always takes a new item.
	`ASSERT_IMPLIES(a_empty_ready, clk, arst_n, !result_valid, item_ready)

	// A stalled result transfer keeps all of its fields.
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, stalled, result_valid && $stable(fields))

endmodule

bind frost_guarded_cooling_controller fgcc_checker u_fgcc_checker (.*);
